// ----- rtl/idr_pkg.sv -----
// ----------------------------------------------------------------------------
// idr_pkg
// Shared types, constants and helper functions for the radix digit converter.
// ----------------------------------------------------------------------------
package idr_pkg;

  localparam int VALUE_W    = 31;
  localparam int SYM_W      = 8;
  localparam int BASE_W     = 5;
  localparam int DIGIT_W    = 4;
  localparam int MAX_RADIX  = 16;
  localparam int MAX_DIGITS = 31;
  localparam int CNT_W      = 5;
  localparam int BIT_CNT_W  = $clog2(VALUE_W);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int ALPHA_W    = 64;

  localparam logic [CFG_IDX_W-1:0] REG_RADIX         = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_HIGH = 2'd2;

  localparam logic [BASE_W-1:0]  RADIX_RESET      = 5'd16;
  localparam logic [ALPHA_W-1:0] ALPHA_LOW_RESET  = 64'd3978425819141910832;
  localparam logic [ALPHA_W-1:0] ALPHA_HIGH_RESET = 64'd5063528411713059128;

  typedef struct packed {
    logic start;
    logic step;
    logic push;
    logic pop;
  } idr_cmd_t;

  typedef struct packed {
    logic bit_done;
    logic quo_zero;
    logic stack_full;
    logic emit_last;
  } idr_status_t;

  function automatic logic [BASE_W-1:0] eff_radix(input logic [BASE_W-1:0] base);
    logic [BASE_W-1:0] r;
    r = base;
    if (r < BASE_W'(2)) begin
      r = BASE_W'(2);
    end else if (r > BASE_W'(MAX_RADIX)) begin
      r = BASE_W'(MAX_RADIX);
    end
    return r;
  endfunction

  function automatic logic [SYM_W-1:0] symbol_of(input logic [DIGIT_W-1:0] d,
                                                 input logic [ALPHA_W-1:0] lo,
                                                 input logic [ALPHA_W-1:0] hi);
    logic [ALPHA_W-1:0] word;
    logic [5:0]         sh;
    word = d[3] ? hi : lo;
    sh   = {d[2:0], 3'b000};
    return word[sh +: SYM_W];
  endfunction

endpackage

// ----- rtl/idr_in_if.sv -----
// ----------------------------------------------------------------------------
// idr_in_if
// Input channel: one integer word per handshake.
// ----------------------------------------------------------------------------
interface idr_in_if import idr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ----- rtl/idr_out_if.sv -----
// ----------------------------------------------------------------------------
// idr_out_if
// Output channel: one character word per handshake, last flags end of number.
// ----------------------------------------------------------------------------
interface idr_out_if import idr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
endinterface

// ----- rtl/idr_datapath.sv -----
// ----------------------------------------------------------------------------
// idr_datapath
// Config registers, bit-serial restoring divider, digit stack and output reg.
// ----------------------------------------------------------------------------
module idr_datapath import idr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [VALUE_W-1:0]    value,
  input  idr_cmd_t              cmd,
  output idr_status_t           status,
  output logic [SYM_W-1:0]      symbol,
  output logic                  last
);

  logic [BASE_W-1:0]    radix_cfg;
  logic [ALPHA_W-1:0]   alpha_low;
  logic [ALPHA_W-1:0]   alpha_high;
  logic [VALUE_W-1:0]   work;
  logic [DIGIT_W-1:0]   rem;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic [CNT_W-1:0]     count;
  logic [DIGIT_W-1:0]   stack [MAX_DIGITS];

  logic [BASE_W-1:0]    radix;
  logic [BASE_W-1:0]    rem_shift;
  logic [BASE_W-1:0]    rem_sub;
  logic                 ge;
  logic [DIGIT_W-1:0]   rem_next;
  logic [CNT_W-1:0]     top;

  always_comb begin
    radix     = eff_radix(radix_cfg);
    rem_shift = {rem, work[VALUE_W-1]};
    ge        = rem_shift >= radix;
    rem_sub   = rem_shift - radix;
    rem_next  = ge ? rem_sub[DIGIT_W-1:0] : rem_shift[DIGIT_W-1:0];
    top       = count - CNT_W'(1);
  end

  always_comb begin
    status.bit_done   = bit_cnt == BIT_CNT_W'(VALUE_W - 1);
    status.quo_zero   = work == '0;
    status.stack_full = count == CNT_W'(MAX_DIGITS - 1);
    status.emit_last  = count == CNT_W'(1);
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      radix_cfg  <= RADIX_RESET;
      alpha_low  <= ALPHA_LOW_RESET;
      alpha_high <= ALPHA_HIGH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RADIX:         radix_cfg  <= cfg_data[BASE_W-1:0];
        REG_ALPHABET_LOW:  alpha_low  <= cfg_data[ALPHA_W-1:0];
        REG_ALPHABET_HIGH: alpha_high <= cfg_data[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  // divider and digit count
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      bit_cnt <= '0;
    end else begin
      if (cmd.start) begin
        count   <= '0;
        bit_cnt <= '0;
      end else if (cmd.step) begin
        bit_cnt <= bit_cnt + BIT_CNT_W'(1);
      end else if (cmd.push) begin
        count   <= count + CNT_W'(1);
        bit_cnt <= '0;
      end else if (cmd.pop) begin
        count <= top;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      work <= value;
      rem  <= '0;
    end else if (cmd.step) begin
      work <= {work[VALUE_W-2:0], ge};
      rem  <= rem_next;
    end else if (cmd.push) begin
      rem <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stack[count] <= rem;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      symbol <= symbol_of(stack[top], alpha_low, alpha_high);
      last   <= status.emit_last;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_DIGITS))
    else $error("digit count beyond stack depth");

  a_push_after_div: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> $past(cmd.step) && $past(status.bit_done))
    else $error("digit pushed before division finished");

  a_pop_has_digit: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> count != '0)
    else $error("pop from empty digit stack");

endmodule

// ----- rtl/idr_controller.sv -----
// ----------------------------------------------------------------------------
// idr_controller
// Sequencer: accept, divide digit by digit, then pop digits to the output.
// ----------------------------------------------------------------------------
module idr_controller import idr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  idr_status_t status,
  output idr_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_PUSH = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = state == S_IDLE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (status.bit_done) begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push = 1'b1;
        if (status.quo_zero || status.stack_full) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_DIV;
        end
      end
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          cmd.pop = 1'b1;
          if (status.emit_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    priority if (cmd.pop) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_pop_needs_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> !out_valid || out_ready)
    else $error("output word overwritten");

  a_short_number: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH && status.quo_zero) |=> state == S_EMIT)
    else $error("conversion did not stop at zero quotient");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !cmd.step && !cmd.push && !cmd.pop)
    else $error("datapath command while idle");

endmodule

// ----- rtl/integer_to_radix_digits.sv -----
// ----------------------------------------------------------------------------
// integer_to_radix_digits
// Converts a 31-bit integer to alphabet characters in a configurable radix.
// ----------------------------------------------------------------------------
// one number at a time: per digit, one divider step per value bit, then a push
// then characters pop out, one per cycle while the output is free
// input is ready only in idle; a number has at most 31 digits
// the bit-serial divider, one quotient bit per cycle, sets the rate
// reset clears the sequencer and output valid and restores the config
// registers; the digit stack is not cleared
module integer_to_radix_digits import idr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  idr_in_if.sink                number,
  idr_out_if.source             chars
);

  idr_cmd_t    cmd;
  idr_status_t status;

  idr_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (number.valid),
    .in_ready  (number.ready),
    .out_valid (chars.valid),
    .out_ready (chars.ready),
    .status    (status),
    .cmd       (cmd)
  );

  idr_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .value     (number.value),
    .cmd       (cmd),
    .status    (status),
    .symbol    (chars.symbol),
    .last      (chars.last)
  );

endmodule
